FILE: rtl/vbfp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the vision block frame parser.
// No dependencies; imported by every module of the block.
package vbfp_pkg;

   localparam int WORD_W      = 16;
   localparam int CENTROID_W  = 18;
   localparam int OFFSET_W    = 17;
   localparam int BLOCK_WORDS_DEF = 6;
   localparam int CSR_IDX_W   = 2;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_WORD   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_OFF  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_SIG   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_SIG  = 2'd3;

   // Reset values of the registers
   localparam logic [WORD_W-1:0] SYNC_WORD_RST   = 16'hAA55;
   localparam logic [WORD_W-1:0] CENTER_OFF_RST  = 16'd160;
   localparam logic [WORD_W-1:0] FIRST_SIG_RST   = 16'd1;
   localparam logic [WORD_W-1:0] SECOND_SIG_RST  = 16'd2;

   // Word positions inside a block
   localparam int SIG_POS = 1;
   localparam int X_POS   = 2;

   typedef struct packed {
      logic [WORD_W-1:0] sync_word;
      logic [WORD_W-1:0] center_offset;
      logic [WORD_W-1:0] first_signature;
      logic [WORD_W-1:0] second_signature;
   } cfg_type;

   typedef struct packed {
      logic                         valid;
      logic                         found;
      logic signed [CENTROID_W-1:0] centroid;
   } res_type;

   typedef enum logic [4:0] {
      PH_UNSYNC = 5'b00001,
      PH_SYNC2  = 5'b00010,
      PH_GATHER = 5'b00100,
      PH_BLKEND = 5'b01000,
      PH_FRMEND = 5'b10000
   } phase_type;

endpackage

FILE: rtl/vbfp_parser.sv
`timescale 1ns / 1ps
// Frame parse state machine, block capture and offset tracking.
// Depends on vbfp_pkg; one word is consumed per step_valid cycle.
module vbfp_parser
   import vbfp_pkg::*;
#(
   parameter int BLOCK_WORDS = BLOCK_WORDS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_valid,
   input  logic [WORD_W-1:0] step_word,
   input  cfg_type           cfg,
   output res_type           res
);

   localparam int IDX_W = $clog2(BLOCK_WORDS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BLOCK_WORDS - 1);
   localparam logic [IDX_W-1:0] SIG_IDX  = IDX_W'(SIG_POS);
   localparam logic [IDX_W-1:0] X_IDX    = IDX_W'(X_POS);

   phase_type                     phase_ff, phase_in;
   logic [IDX_W-1:0]              index_ff, index_in;
   logic [WORD_W-1:0]             sig_ff, sig_in;
   logic [WORD_W-1:0]             x_ff, x_in;
   logic signed [OFFSET_W-1:0]    first_ff, first_in;
   logic signed [OFFSET_W-1:0]    block_off;
   logic                          is_sync;
   logic                          is_zero;

   assign is_sync   = (step_word == cfg.sync_word);
   assign is_zero   = (step_word == '0);
   assign block_off = $signed({1'b0, x_ff}) - $signed({1'b0, cfg.center_offset});

   // Next state and result for the word at the parser input
   always_comb begin
      phase_in  = phase_ff;
      index_in  = index_ff;
      sig_in    = sig_ff;
      x_in      = x_ff;
      first_in  = first_ff;
      res       = '0;
      case (phase_ff)
         PH_UNSYNC: begin
            if (is_sync) begin
               phase_in = PH_SYNC2;
            end else if (is_zero) begin
               res.valid = 1'b1;
            end
         end
         PH_SYNC2: begin
            if (is_sync) begin
               index_in  = '0;
               first_in  = '0;
               phase_in  = PH_GATHER;
            end else begin
               res.valid = is_zero;
               phase_in  = PH_UNSYNC;
            end
         end
         PH_GATHER: begin
            // capture only the words that are read at block end
            if (index_ff == SIG_IDX) sig_in = step_word;
            if (index_ff == X_IDX)   x_in   = step_word;
            if (index_ff == LAST_IDX) begin
               index_in = '0;
               phase_in = PH_BLKEND;
            end else begin
               index_in = index_ff + 1'b1;
            end
         end
         PH_BLKEND: begin
            if (is_sync) begin
               index_in = '0;
               phase_in = PH_FRMEND;
               if (sig_ff == cfg.first_signature) begin
                  first_in = block_off;
               end else if (sig_ff == cfg.second_signature) begin
                  // second offset is the current block's, so report directly
                  res.valid    = 1'b1;
                  res.found    = 1'b1;
                  res.centroid = CENTROID_W'(first_ff) + CENTROID_W'(block_off);
               end
            end else begin
               phase_in = PH_UNSYNC;
            end
         end
         PH_FRMEND: begin
            if (is_sync) begin
               index_in = '0;
               phase_in = PH_GATHER;
            end else if (is_zero) begin
               res.valid = 1'b1;
               phase_in  = PH_UNSYNC;
            end else begin
               // word 0 of a new block: checksum, not kept
               index_in = IDX_W'(1);
               phase_in = PH_GATHER;
            end
         end
         default: begin
            phase_in = PH_UNSYNC;
         end
      endcase
      if (!step_valid) begin
         res.valid = 1'b0;
      end
   end

   // Advance control state on each consumed word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_UNSYNC;
         index_ff  <= '0;
         first_ff  <= '0;
      end else if (step_valid) begin
         phase_ff  <= phase_in;
         index_ff  <= index_in;
         first_ff  <= first_in;
      end
   end

   // Block words carry no reset
   always_ff @(posedge clock) begin
      if (step_valid) begin
         sig_ff <= sig_in;
         x_ff   <= x_in;
      end
   end

endmodule

FILE: rtl/vbfp_out_reg.sv
`timescale 1ns / 1ps
// Result register on the rsp channel: holds one result until transferred.
// Depends on vbfp_pkg for the result type.
module vbfp_out_reg
   import vbfp_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  res_type                      res,
   output logic                         space,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_target_found,
   output logic signed [CENTROID_W-1:0] rsp_centroid_doubled
);

   logic                         valid_ff, valid_in;
   logic                         found_ff;
   logic signed [CENTROID_W-1:0] centroid_ff;

   // Free this cycle if empty or the held result transfers now
   assign space = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = res.valid;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload loads only with a new result
   always_ff @(posedge clock) begin
      if (load && res.valid) begin
         found_ff    <= res.found;
         centroid_ff <= res.centroid;
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_target_found     = found_ff;
   assign rsp_centroid_doubled = centroid_ff;

endmodule

FILE: rtl/vision_block_frame_parser_core.sv
`timescale 1ns / 1ps
// Vision block frame parser: top level with input register and csr registers.
// Path: a req word passes the input register and the parser into the result register that drives rsp_valid.
// Throughput: one word per cycle; a held result with rsp_ready low stalls the input register.
// Reset (synchronous): parser unsynchronised, offsets zero, csr registers at defaults.
// Depends on vbfp_pkg, vbfp_parser and vbfp_out_reg.
module vision_block_frame_parser_core
   import vbfp_pkg::*;
#(
   parameter int BLOCK_WORDS = BLOCK_WORDS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [WORD_W-1:0]            req_data_word,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_target_found,
   output logic signed [CENTROID_W-1:0] rsp_centroid_doubled,
   input  logic                         csr_write,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [WORD_W-1:0]            csr_data
);

   cfg_type           cfg_ff;
   logic              in_valid_ff, in_valid_in;
   logic [WORD_W-1:0] in_word_ff;
   logic              out_space;
   logic              step;
   res_type           res;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_word        <= SYNC_WORD_RST;
         cfg_ff.center_offset    <= CENTER_OFF_RST;
         cfg_ff.first_signature  <= FIRST_SIG_RST;
         cfg_ff.second_signature <= SECOND_SIG_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SYNC_WORD:  cfg_ff.sync_word        <= csr_data;
            CSR_CENTER_OFF: cfg_ff.center_offset    <= csr_data;
            CSR_FIRST_SIG:  cfg_ff.first_signature  <= csr_data;
            CSR_SECOND_SIG: cfg_ff.second_signature <= csr_data;
            default: ;
         endcase
      end
   end

   // Input register: step the parser when the result side has room
   assign step      = in_valid_ff && out_space;
   assign req_ready = !in_valid_ff || step;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff <= req_data_word;
      end
   end

   vbfp_parser #(
      .BLOCK_WORDS(BLOCK_WORDS)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .step_valid (step),
      .step_word  (in_word_ff),
      .cfg        (cfg_ff),
      .res        (res)
   );

   vbfp_out_reg u_out_reg (
      .clock                (clock),
      .reset                (reset),
      .load                 (step),
      .res                  (res),
      .space                (out_space),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_target_found     (rsp_target_found),
      .rsp_centroid_doubled (rsp_centroid_doubled)
   );

   // A cleared result always carries a zero centroid
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_target_found) |-> (rsp_centroid_doubled == '0))
      else $error("clear result with nonzero centroid");

   // Never take a word while the input register is held
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_space) |-> !req_ready)
      else $error("input register overwritten while stalled");

   // Nothing is offered in the cycle after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

   // A word leaves the input register only when it was stepped
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !step && !(req_valid && req_ready)) |=> in_valid_ff)
      else $error("input word dropped");

endmodule
